[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked during reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/bta_pkg.sv]
// Package with widths, codes and types of the blit texture address generator.
package bta_pkg;

    localparam int C          = 12;
    localparam int SW         = C + 1;
    localparam int AW         = 2 * C;
    localparam int NW         = 2 * C;
    localparam int DW         = C + 1;
    localparam int RW         = C + 1;
    localparam int DIV_STAGES = NW;
    localparam int IDX_W      = 3;
    localparam int MODE_W     = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE    = 3'd0,
        MODE_WRAP    = 3'd1,
        MODE_CLAMP   = 3'd2,
        MODE_MIRROR  = 3'd3,
        MODE_STRETCH = 3'd4
    } t_mode;

    typedef enum logic [IDX_W-1:0] {
        CFG_ADDRESS_MODE    = 3'd0,
        CFG_SRC_IMAGE_SIZE  = 3'd1,
        CFG_SRC_RECT_ORIGIN = 3'd2,
        CFG_SRC_RECT_SIZE   = 3'd3,
        CFG_DST_RECT_ORIGIN = 3'd4,
        CFG_DST_RECT_SIZE   = 3'd5,
        CFG_DST_IMAGE_SIZE  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [C-1:0] y;
        logic [C-1:0] x;
    } t_xy;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        t_xy               src_image_size;
        t_xy               src_rect_origin;
        t_xy               src_rect_size;
        t_xy               dst_rect_origin;
        t_xy               dst_rect_size;
        t_xy               dst_image_size;
    } t_cfg;

    // Per-item data that rides alongside the divider.
    typedef struct packed {
        logic [SW-1:0] sum_x;
        logic [SW-1:0] sum_y;
        logic [SW-1:0] dst_x;
        logic [SW-1:0] dst_y;
    } t_side;

endpackage

[rtl/core/bta_front.sv]
// Front stages: input capture, origin adds, stretch product and divider operand select.
module bta_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  bta_pkg::t_cfg        i_cfg,
    input  logic                 i_valid,
    input  logic [bta_pkg::C-1:0] i_offset_x,
    input  logic [bta_pkg::C-1:0] i_offset_y,
    output logic                 o_valid,
    output logic [bta_pkg::NW-1:0] o_num_x,
    output logic [bta_pkg::NW-1:0] o_num_y,
    output bta_pkg::t_side       o_side
);
    import bta_pkg::*;

    logic          r_v0, r_v1;
    logic [C-1:0]  r_ox, r_oy;
    logic [NW-1:0] r_num_x, r_num_y;
    t_side         r_side;
    logic [NW-1:0] n_num_x, n_num_y;
    t_side         n_side;

    // Picks the dividend that the current mode divides.
    function automatic logic [NW-1:0] f_num(input logic [MODE_W-1:0] mode,
                                            input logic [C-1:0] off,
                                            input logic [SW-1:0] sum,
                                            input logic [C-1:0] rsize);
        logic [NW-1:0] r;
        unique case (t_mode'(mode))
            MODE_WRAP:    r = NW'(off);
            MODE_MIRROR:  r = NW'(sum);
            MODE_STRETCH: r = NW'(off * rsize);
            default:      r = '0;
        endcase
        return r;
    endfunction

    // Operands for the divider stage.
    always_comb begin
        n_side.sum_x = SW'(i_cfg.src_rect_origin.x) + SW'(r_ox);
        n_side.sum_y = SW'(i_cfg.src_rect_origin.y) + SW'(r_oy);
        n_side.dst_x = SW'(i_cfg.dst_rect_origin.x) + SW'(r_ox);
        n_side.dst_y = SW'(i_cfg.dst_rect_origin.y) + SW'(r_oy);
        n_num_x = f_num(i_cfg.mode, r_ox, n_side.sum_x, i_cfg.src_rect_size.x);
        n_num_y = f_num(i_cfg.mode, r_oy, n_side.sum_y, i_cfg.src_rect_size.y);
    end

    // Valid bits of the two front stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
        end
    end

    // Payload of the two front stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ox    <= i_offset_x;
            r_oy    <= i_offset_y;
            r_num_x <= n_num_x;
            r_num_y <= n_num_y;
            r_side  <= n_side;
        end
    end

    assign o_valid = r_v1;
    assign o_num_x = r_num_x;
    assign o_num_y = r_num_y;
    assign o_side  = r_side;

endmodule

[rtl/core/bta_div_pipe.sv]
// Pipelined restoring divider for both axes, one quotient bit per stage.
module bta_div_pipe (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [bta_pkg::NW-1:0] i_num_x,
    input  logic [bta_pkg::NW-1:0] i_num_y,
    input  logic [bta_pkg::DW-1:0] i_den_x,
    input  logic [bta_pkg::DW-1:0] i_den_y,
    input  bta_pkg::t_side         i_side,
    output logic                   o_valid,
    output logic [bta_pkg::NW-1:0] o_quo_x,
    output logic [bta_pkg::NW-1:0] o_quo_y,
    output logic [bta_pkg::RW-1:0] o_rem_x,
    output logic [bta_pkg::RW-1:0] o_rem_y,
    output bta_pkg::t_side         o_side
);
    import bta_pkg::*;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [NW-1:0] num;
    } t_dstep;

    logic   r_v     [DIV_STAGES];
    t_dstep r_x     [DIV_STAGES];
    t_dstep r_y     [DIV_STAGES];
    t_side  r_side  [DIV_STAGES];
    t_dstep n_x     [DIV_STAGES];
    t_dstep n_y     [DIV_STAGES];

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    function automatic t_dstep f_step(input t_dstep cur, input logic [DW-1:0] den);
        logic [RW:0] t;
        t_dstep      s;
        t = {cur.rem, cur.num[NW-1]};
        if (t >= {1'b0, den}) begin
            s.rem = RW'(t - {1'b0, den});
            s.num = {cur.num[NW-2:0], 1'b1};
        end else begin
            s.rem = t[RW-1:0];
            s.num = {cur.num[NW-2:0], 1'b0};
        end
        return s;
    endfunction

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        if (g == 0) begin : g_first
            // The first stage starts from a zero remainder.
            always_comb begin
                n_x[g] = f_step('{rem: '0, num: i_num_x}, i_den_x);
                n_y[g] = f_step('{rem: '0, num: i_num_y}, i_den_y);
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[g] <= 1'b0;
                end else if (i_en) begin
                    r_v[g] <= i_valid;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[g]    <= n_x[g];
                    r_y[g]    <= n_y[g];
                    r_side[g] <= i_side;
                end
            end
        end else begin : g_next
            // Later stages continue from the stage before.
            always_comb begin
                n_x[g] = f_step(r_x[g-1], i_den_x);
                n_y[g] = f_step(r_y[g-1], i_den_y);
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[g] <= 1'b0;
                end else if (i_en) begin
                    r_v[g] <= r_v[g-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[g]    <= n_x[g];
                    r_y[g]    <= n_y[g];
                    r_side[g] <= r_side[g-1];
                end
            end
        end
    end

    assign o_valid = r_v[DIV_STAGES-1];
    assign o_quo_x = r_x[DIV_STAGES-1].num;
    assign o_quo_y = r_y[DIV_STAGES-1].num;
    assign o_rem_x = r_x[DIV_STAGES-1].rem;
    assign o_rem_y = r_y[DIV_STAGES-1].rem;
    assign o_side  = r_side[DIV_STAGES-1];

endmodule

[rtl/core/bta_back.sv]
// Back stages: mode mapping, row multiplies, flags and the output register.
module bta_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  bta_pkg::t_cfg          i_cfg,
    input  logic                   i_valid,
    input  logic [bta_pkg::NW-1:0] i_quo_x,
    input  logic [bta_pkg::NW-1:0] i_quo_y,
    input  logic [bta_pkg::RW-1:0] i_rem_x,
    input  logic [bta_pkg::RW-1:0] i_rem_y,
    input  bta_pkg::t_side         i_side,
    output logic                   o_valid,
    output logic [bta_pkg::AW-1:0] o_source_address,
    output logic [bta_pkg::AW-1:0] o_dest_address,
    output logic                   o_write_enable,
    output logic                   o_source_in_range
);
    import bta_pkg::*;

    logic          r_vp, r_vm, r_vo;
    logic [SW-1:0] r_sx, r_sy, r_dx, r_dy;
    logic [SW-1:0] r_sx_m, r_dx_m;
    logic [AW-1:0] r_sprod, r_dprod;
    logic          r_we_m, r_sin_m;
    logic [AW-1:0] r_src_addr, r_dst_addr;
    logic          r_we, r_sin;
    logic [SW-1:0] n_sx, n_sy;

    // Maps one axis to its source coordinate by the address mode.
    function automatic logic [SW-1:0] f_map(input logic [MODE_W-1:0] mode,
                                            input logic [C-1:0] org,
                                            input logic [SW-1:0] sum,
                                            input logic [NW-1:0] quo,
                                            input logic [RW-1:0] rem,
                                            input logic [C-1:0] rsize,
                                            input logic [C-1:0] isize,
                                            input logic [C-1:0] dsize);
        logic [SW-1:0] lim;
        logic [NW:0]   st;
        logic [SW-1:0] r;
        lim = (isize == '0) ? '0 : SW'(isize) - SW'(1);
        st  = '0;
        unique case (t_mode'(mode))
            MODE_WRAP: begin
                r = (rsize == '0) ? SW'(org) : SW'(org) + SW'(rem);
            end
            MODE_CLAMP: begin
                r = (sum > lim) ? lim : sum;
            end
            MODE_MIRROR: begin
                if (isize == '0) begin
                    r = '0;
                end else if (rem >= RW'(isize)) begin
                    r = SW'({isize, 1'b0} - SW'(rem) - SW'(1));
                end else begin
                    r = SW'(rem);
                end
            end
            MODE_STRETCH: begin
                st = (dsize == '0) ? (NW+1)'(org) : (NW+1)'(org) + (NW+1)'(quo);
                r  = (st > (NW+1)'(lim)) ? lim : st[SW-1:0];
            end
            default: begin
                r = sum;
            end
        endcase
        return r;
    endfunction

    always_comb begin
        n_sx = f_map(i_cfg.mode, i_cfg.src_rect_origin.x, i_side.sum_x, i_quo_x, i_rem_x,
                     i_cfg.src_rect_size.x, i_cfg.src_image_size.x, i_cfg.dst_rect_size.x);
        n_sy = f_map(i_cfg.mode, i_cfg.src_rect_origin.y, i_side.sum_y, i_quo_y, i_rem_y,
                     i_cfg.src_rect_size.y, i_cfg.src_image_size.y, i_cfg.dst_rect_size.y);
    end

    // Valid bits of the three back stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
            r_vm <= 1'b0;
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vp <= i_valid;
            r_vm <= r_vp;
            r_vo <= r_vm;
        end
    end

    // Mapping, multiply and final add stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx       <= n_sx;
            r_sy       <= n_sy;
            r_dx       <= i_side.dst_x;
            r_dy       <= i_side.dst_y;
            r_sprod    <= AW'(r_sy * i_cfg.src_image_size.x);
            r_dprod    <= AW'(r_dy * i_cfg.dst_image_size.x);
            r_sx_m     <= r_sx;
            r_dx_m     <= r_dx;
            r_sin_m    <= (r_sx < SW'(i_cfg.src_image_size.x)) &&
                          (r_sy < SW'(i_cfg.src_image_size.y));
            r_we_m     <= (r_dx < SW'(i_cfg.dst_image_size.x)) &&
                          (r_dy < SW'(i_cfg.dst_image_size.y));
            r_src_addr <= r_sprod + AW'(r_sx_m);
            r_dst_addr <= r_dprod + AW'(r_dx_m);
            r_sin      <= r_sin_m;
            r_we       <= r_we_m;
        end
    end

    assign o_valid           = r_vo;
    assign o_source_address  = r_src_addr;
    assign o_dest_address    = r_dst_addr;
    assign o_write_enable    = r_we;
    assign o_source_in_range = r_sin;

endmodule

[rtl/core/blit_texture_address_gen.sv]
// Top level of the blit texture address generator.
// One beat in, one beat out: the block takes one destination offset per clock and
// gives its source and destination addresses after the front, divider and back
// stages; the whole pipeline holds while a finished beat is stalled at the output
// register. The restoring divider serves wrap, mirror and stretch, one quotient bit
// per stage. The user must write configuration only while idle; it is not enforced.
module blit_texture_address_gen (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [bta_pkg::C-1:0]       i_offset_x,
    input  logic [bta_pkg::C-1:0]       i_offset_y,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [bta_pkg::AW-1:0]      o_source_address,
    output logic [bta_pkg::AW-1:0]      o_dest_address,
    output logic                        o_write_enable,
    output logic                        o_source_in_range,
    input  logic                        i_cfg_we,
    input  logic [bta_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [bta_pkg::AW-1:0]      i_cfg_data
);
    import bta_pkg::*;

    t_cfg          r_cfg;
    logic          en;
    logic          f_valid, d_valid;
    logic [NW-1:0] f_num_x, f_num_y;
    t_side         f_side, d_side;
    logic [NW-1:0] d_quo_x, d_quo_y;
    logic [RW-1:0] d_rem_x, d_rem_y;
    logic [DW-1:0] den_x, den_y;
    localparam t_xy ONE_ONE = '{y: C'(1), x: C'(1)};

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode            <= MODE_NONE;
            r_cfg.src_image_size  <= ONE_ONE;
            r_cfg.src_rect_origin <= '0;
            r_cfg.src_rect_size   <= ONE_ONE;
            r_cfg.dst_rect_origin <= '0;
            r_cfg.dst_rect_size   <= ONE_ONE;
            r_cfg.dst_image_size  <= ONE_ONE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ADDRESS_MODE:    r_cfg.mode            <= i_cfg_data[MODE_W-1:0];
                CFG_SRC_IMAGE_SIZE:  r_cfg.src_image_size  <= i_cfg_data;
                CFG_SRC_RECT_ORIGIN: r_cfg.src_rect_origin <= i_cfg_data;
                CFG_SRC_RECT_SIZE:   r_cfg.src_rect_size   <= i_cfg_data;
                CFG_DST_RECT_ORIGIN: r_cfg.dst_rect_origin <= i_cfg_data;
                CFG_DST_RECT_SIZE:   r_cfg.dst_rect_size   <= i_cfg_data;
                CFG_DST_IMAGE_SIZE:  r_cfg.dst_image_size  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline advances unless the output beat is stalled.
    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = o_out_valid && i_out_stall;

    // Divisors depend only on configuration.
    always_comb begin
        unique case (t_mode'(r_cfg.mode))
            MODE_WRAP: begin
                den_x = DW'(r_cfg.src_rect_size.x);
                den_y = DW'(r_cfg.src_rect_size.y);
            end
            MODE_MIRROR: begin
                den_x = {r_cfg.src_image_size.x, 1'b0};
                den_y = {r_cfg.src_image_size.y, 1'b0};
            end
            MODE_STRETCH: begin
                den_x = DW'(r_cfg.dst_rect_size.x);
                den_y = DW'(r_cfg.dst_rect_size.y);
            end
            default: begin
                den_x = DW'(1);
                den_y = DW'(1);
            end
        endcase
    end

    bta_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_cfg      (r_cfg),
        .i_valid    (i_in_valid),
        .i_offset_x (i_offset_x),
        .i_offset_y (i_offset_y),
        .o_valid    (f_valid),
        .o_num_x    (f_num_x),
        .o_num_y    (f_num_y),
        .o_side     (f_side)
    );

    bta_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_num_x (f_num_x),
        .i_num_y (f_num_y),
        .i_den_x (den_x),
        .i_den_y (den_y),
        .i_side  (f_side),
        .o_valid (d_valid),
        .o_quo_x (d_quo_x),
        .o_quo_y (d_quo_y),
        .o_rem_x (d_rem_x),
        .o_rem_y (d_rem_y),
        .o_side  (d_side)
    );

    bta_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (en),
        .i_cfg             (r_cfg),
        .i_valid           (d_valid),
        .i_quo_x           (d_quo_x),
        .i_quo_y           (d_quo_y),
        .i_rem_x           (d_rem_x),
        .i_rem_y           (d_rem_y),
        .i_side            (d_side),
        .o_valid           (o_out_valid),
        .o_source_address  (o_source_address),
        .o_dest_address    (o_dest_address),
        .o_write_enable    (o_write_enable),
        .o_source_in_range (o_source_in_range)
    );

endmodule

[rtl/core/bta_checker.sv]
// Port-level checker for the blit texture address generator, with its bind.
`include "assert_macros.svh"

module bta_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [bta_pkg::AW-1:0]    o_source_address,
    input logic [bta_pkg::AW-1:0]    o_dest_address
);

    // A stalled output beat holds its payload.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_source_address) && $stable(o_dest_address), "stalled output beat changed")

    // The input is held back only by a stalled output beat.
    `ASSERT_IMPL(a_in_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stalled without output stall")

    // A stalled output beat always holds the input back.
    `ASSERT_IMPL(a_in_stall_back, i_clk, i_rst_n, o_out_valid && i_out_stall, o_in_stall, "input accepted while output stalled")

    // Reset empties the pipeline.
    `ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid, "output valid after reset")

endmodule

bind blit_texture_address_gen bta_checker u_bta_checker (.*);

[test/tb.sv]
// Self-checking testbench of the blit texture address generator.
`timescale 1ns / 1ps

module tb;
    import bta_pkg::*;

    localparam int LATENCY   = 2 * C + 5;
    localparam int WDOG_MAX  = 4000;
    localparam int N_RANDOM  = 520;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_stall;
    logic [C-1:0]  i_offset_x;
    logic [C-1:0]  i_offset_y;
    logic          o_out_valid;
    logic          i_out_stall;
    logic [AW-1:0] o_source_address;
    logic [AW-1:0] o_dest_address;
    logic          o_write_enable;
    logic          o_source_in_range;
    logic          i_cfg_we;
    logic [IDX_W-1:0] i_cfg_index;
    logic [AW-1:0] i_cfg_data;

    typedef struct packed {
        logic [AW-1:0] src_addr;
        logic [AW-1:0] dst_addr;
        logic          we;
        logic          src_ok;
    } t_addr_beat;

    // One row of the directed table: offset, and an optional typed-in answer.
    typedef struct {
        logic [C-1:0] ox;
        logic [C-1:0] oy;
        bit           has_fixed;
        t_addr_beat   fixed;
    } t_row;

    t_addr_beat addr_queue[$];
    t_cfg       shadow;
    int         errors;
    int         idle_cycles;
    bit         quiet_mode;
    bit         hold_rx;
    bit         out_phase;

    blit_texture_address_gen dut (.*);

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Predictor helpers at 64 bits, the coordinates fit easily.
    function automatic longint unsigned clamp_coord(longint unsigned c, longint unsigned sz);
        longint unsigned lim;
        lim = (sz == 0) ? 0 : sz - 1;
        return (c > lim) ? lim : c;
    endfunction

    function automatic longint unsigned map_coord(logic [MODE_W-1:0] mode,
            longint unsigned org, longint unsigned off, longint unsigned rsz,
            longint unsigned isz, longint unsigned dsz);
        longint unsigned c;
        case (mode)
            MODE_WRAP: begin
                return org + ((rsz == 0) ? 0 : off % rsz);
            end
            MODE_CLAMP: begin
                return clamp_coord(org + off, isz);
            end
            MODE_MIRROR: begin
                if (isz == 0) return 0;
                c = (org + off) % (2 * isz);
                return (c >= isz) ? 2 * isz - c - 1 : c;
            end
            MODE_STRETCH: begin
                return clamp_coord(org + ((dsz == 0) ? 0 : (off * rsz) / dsz), isz);
            end
            default: begin
                return org + off;
            end
        endcase
    endfunction

    function automatic t_addr_beat predict_addresses(logic [C-1:0] ox, logic [C-1:0] oy);
        t_addr_beat r;
        longint unsigned dx, dy, sx, sy, siw, sih, diw, dih;
        siw = 64'(shadow.src_image_size.x);
        sih = 64'(shadow.src_image_size.y);
        diw = 64'(shadow.dst_image_size.x);
        dih = 64'(shadow.dst_image_size.y);
        dx = 64'(shadow.dst_rect_origin.x) + 64'(ox);
        dy = 64'(shadow.dst_rect_origin.y) + 64'(oy);
        sx = map_coord(shadow.mode, 64'(shadow.src_rect_origin.x), 64'(ox),
                       64'(shadow.src_rect_size.x), siw, 64'(shadow.dst_rect_size.x));
        sy = map_coord(shadow.mode, 64'(shadow.src_rect_origin.y), 64'(oy),
                       64'(shadow.src_rect_size.y), sih, 64'(shadow.dst_rect_size.y));
        r.src_addr = AW'(sy * siw + sx);
        r.dst_addr = AW'(dy * diw + dx);
        r.we       = (dx < diw) && (dy < dih);
        r.src_ok   = (sx < siw) && (sy < sih);
        return r;
    endfunction

    // Register write while idle; the shadow copy follows it.
    task automatic write_reg(t_cfg_idx idx, logic [AW-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_ADDRESS_MODE:    shadow.mode            = value[MODE_W-1:0];
            CFG_SRC_IMAGE_SIZE:  shadow.src_image_size  = value;
            CFG_SRC_RECT_ORIGIN: shadow.src_rect_origin = value;
            CFG_SRC_RECT_SIZE:   shadow.src_rect_size   = value;
            CFG_DST_RECT_ORIGIN: shadow.dst_rect_origin = value;
            CFG_DST_RECT_SIZE:   shadow.dst_rect_size   = value;
            CFG_DST_IMAGE_SIZE:  shadow.dst_image_size  = value;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Wait for every expected beat, then let the pipeline drain.
    task automatic drain;
        i_in_valid <= 1'b0;
        while (addr_queue.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    // Offer one input beat, with random gaps first, until it is taken.
    task automatic send_offset(logic [C-1:0] ox, logic [C-1:0] oy, bit has_fixed,
                               t_addr_beat fixed);
        t_addr_beat e;
        while (!quiet_mode && $urandom_range(99) < 15) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        e = has_fixed ? fixed : predict_addresses(ox, oy);
        i_in_valid <= 1'b1;
        i_offset_x <= ox;
        i_offset_y <= oy;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        addr_queue.push_back(e);
        @(negedge i_clk);
    endtask

    function automatic logic [AW-1:0] rand_xy(int lo);
        t_xy v;
        v.x = C'($urandom_range(4095, lo));
        v.y = C'($urandom_range(4095, lo));
        return v;
    endfunction

    // Small sizes in half of the draws so wrap and mirror fold often.
    function automatic logic [AW-1:0] rand_size;
        t_xy v;
        case ($urandom_range(3))
            0: begin v.x = C'($urandom_range(16, 1)); v.y = C'($urandom_range(16, 1)); end
            1: begin v.x = C'($urandom_range(4095, 1)); v.y = C'($urandom_range(4095, 1)); end
            2: begin v.x = 12'hfff; v.y = 12'hfff; end
            default: begin v.x = C'($urandom_range(300, 1)); v.y = C'($urandom_range(300, 1)); end
        endcase
        return v;
    endfunction

    // Receiver: random stall, a quiet stretch, and one long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_rx) begin
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet_mode && ($urandom_range(99) < 15);
        end
    end

    // Checker of output beats against the oldest expectation.
    always @(posedge i_clk) begin
        t_addr_beat e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (addr_queue.size() == 0) begin
                $display("%0t: unexpected beat src=%h dst=%h", $time,
                         o_source_address, o_dest_address);
                errors++;
            end else begin
                e = addr_queue.pop_front();
                if (o_source_address !== e.src_addr) begin
                    $display("%0t: source_address expected %h actual %h", $time,
                             e.src_addr, o_source_address);
                    errors++;
                end
                if (o_dest_address !== e.dst_addr) begin
                    $display("%0t: dest_address expected %h actual %h", $time,
                             e.dst_addr, o_dest_address);
                    errors++;
                end
                if (o_write_enable !== e.we) begin
                    $display("%0t: write_enable expected %b actual %b", $time,
                             e.we, o_write_enable);
                    errors++;
                end
                if (o_source_in_range !== e.src_ok) begin
                    $display("%0t: source_in_range expected %b actual %b", $time,
                             e.src_ok, o_source_in_range);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted beat on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("FAIL blit_texture_address_gen");
                $finish;
            end
        end
    end

    // Long receiver hold-off, counted here while the sender keeps offering.
    always @(negedge i_clk) begin
        if (out_phase) begin
            hold_rx = 1'b1;
            repeat (80) @(negedge i_clk);
            hold_rx = 1'b0;
            out_phase = 1'b0;
        end
    end

    initial begin
        t_row       rows[$];
        t_row       r;
        t_addr_beat z;
        int         n;
        errors      = 0;
        quiet_mode  = 1'b0;
        hold_rx     = 1'b0;
        out_phase   = 1'b0;
        idle_cycles = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_offset_x  = '0;
        i_offset_y  = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_ADDRESS_MODE;
        i_cfg_data  = '0;
        shadow      = '0;
        shadow.src_image_size = {12'd1, 12'd1};
        shadow.src_rect_size  = {12'd1, 12'd1};
        shadow.dst_rect_size  = {12'd1, 12'd1};
        shadow.dst_image_size = {12'd1, 12'd1};
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed rows under reset values: 1x1 images, mode none.
        z = '{src_addr: 24'd0, dst_addr: 24'd0, we: 1'b1, src_ok: 1'b1};
        r = '{ox: 12'd0, oy: 12'd0, has_fixed: 1'b1, fixed: z};
        rows.push_back(r);
        z = '{src_addr: 24'd1, dst_addr: 24'd1, we: 1'b0, src_ok: 1'b0};
        r = '{ox: 12'd1, oy: 12'd0, has_fixed: 1'b1, fixed: z};
        rows.push_back(r);
        z = '{src_addr: 24'd8190, dst_addr: 24'd8190, we: 1'b0, src_ok: 1'b0};
        r = '{ox: 12'hfff, oy: 12'hfff, has_fixed: 1'b1, fixed: z};
        rows.push_back(r);
        foreach (rows[i]) send_offset(rows[i].ox, rows[i].oy, rows[i].has_fixed,
                                      rows[i].fixed);
        drain();

        // Every mode, unused ones too, at extremes and with zero sizes.
        for (int m = 0; m < 8; m++) begin
            rows.delete();
            write_reg(CFG_ADDRESS_MODE, AW'(m));
            write_reg(CFG_SRC_IMAGE_SIZE, (m % 2) ? 24'h000000 : 24'h00a00c);
            write_reg(CFG_SRC_RECT_ORIGIN, (m < 4) ? 24'hfffff0 : 24'h003002);
            write_reg(CFG_SRC_RECT_SIZE, (m == 1) ? 24'h000000 : 24'h005007);
            write_reg(CFG_DST_RECT_ORIGIN, (m < 4) ? 24'hffffff : 24'h000000);
            write_reg(CFG_DST_RECT_SIZE, (m == 4) ? 24'h000000 : 24'h00300d);
            write_reg(CFG_DST_IMAGE_SIZE, (m < 4) ? 24'hffffff : 24'h010010);
            send_offset(12'd0, 12'd0, 1'b0, z);
            send_offset(12'hfff, 12'hfff, 1'b0, z);
            send_offset(12'd5, 12'hfff, 1'b0, z);
            drain();
        end
        // An index beyond the list is ignored.
        i_cfg_we <= 1'b1; i_cfg_index <= 3'd7; i_cfg_data <= 24'hffffff;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);

        // Random phases, each with fresh settings.
        n = 0;
        for (int ph = 0; n < N_RANDOM; ph++) begin
            write_reg(CFG_ADDRESS_MODE, AW'((ph < 10) ? ph % 5 : $urandom_range(7)));
            write_reg(CFG_SRC_IMAGE_SIZE, rand_size());
            write_reg(CFG_SRC_RECT_ORIGIN, ($urandom_range(1)) ? rand_xy(0)
                                                                : AW'($urandom_range(63)));
            write_reg(CFG_SRC_RECT_SIZE, rand_size());
            write_reg(CFG_DST_RECT_ORIGIN, ($urandom_range(1)) ? rand_xy(0)
                                                                : AW'($urandom_range(63)));
            write_reg(CFG_DST_RECT_SIZE, rand_size());
            write_reg(CFG_DST_IMAGE_SIZE, rand_size());
            quiet_mode = (ph == 3);
            if (ph == 5) out_phase = 1'b1;
            for (int k = 0; k < 40; k++) begin
                if ($urandom_range(3) == 0)
                    send_offset(12'($urandom), 12'($urandom), 1'b0, z);
                else
                    send_offset(12'($urandom_range(40)), 12'($urandom_range(40)), 1'b0, z);
                n++;
            end
            quiet_mode = 1'b0;
            // The sender pauses here until every expected beat has come.
            drain();
        end

        if (errors == 0) begin
            $display("PASS blit_texture_address_gen");
        end else begin
            $display("FAIL blit_texture_address_gen");
        end
        $finish;
    end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/bta_pkg.sv
rtl/core/bta_front.sv
rtl/core/bta_div_pipe.sv
rtl/core/bta_back.sv
rtl/core/blit_texture_address_gen.sv
rtl/core/bta_checker.sv
test/tb.sv
